// ----- hw/rtl/prqs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prqs_pkg
// Shared types and constants of the priority ready-queue scheduler.
// ----------------------------------------------------------------------------
package prqs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int LEVEL_BITS_DEF  = 8;

  localparam int FUNC_W   = 2;
  localparam int ID_W     = 4;
  localparam int NUM_IDS  = 1 << ID_W;
  localparam int PRIO_W   = 8;
  localparam int COUNT_W  = 5;
  localparam int ERR_W    = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RESUME   = 2'd0,
    FUNC_SUSPEND  = 2'd1,
    FUNC_SET_PRIO = 2'd2,
    FUNC_SWITCH   = 2'd3
  } prqs_func_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK         = 2'd0,
    ERR_READY      = 2'd1,
    ERR_NOT_QUEUED = 2'd2,
    ERR_FULL       = 2'd3
  } prqs_err_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      start;
    logic      rm_en;
    logic      ins_en;
    logic      ins_cur;
    logic      pop;
    logic      set_level;
    logic      latch_out;
    prqs_err_t err;
  } prqs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic q_hit;
    logic run_hit;
    logic full;
    logic run_valid;
    logic done;
  } prqs_sts_t;

endpackage

// ----- hw/rtl/prqs_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prqs_req_if
// Request channel of the scheduler: one operation per word.
// ----------------------------------------------------------------------------
interface prqs_req_if
  import prqs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   task_id;
  logic [PRIO_W-1:0] prio;
  logic              use_current;

  modport source (output valid, func, task_id, prio, use_current, input ready);
  modport sink   (input valid, func, task_id, prio, use_current, output ready);
endinterface

// ----- hw/rtl/prqs_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prqs_rsp_if
// Response channel of the scheduler: one status word per operation.
// ----------------------------------------------------------------------------
interface prqs_rsp_if
  import prqs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    current_task;
  logic               current_valid;
  logic [PRIO_W-1:0]  current_level;
  logic               preempt_request;
  logic [COUNT_W-1:0] ready_count;
  logic [ERR_W-1:0]   error_code;

  modport source (output valid, current_task, current_valid, current_level,
                  preempt_request, ready_count, error_code, input ready);
  modport sink   (input valid, current_task, current_valid, current_level,
                  preempt_request, ready_count, error_code, output ready);
endinterface

// ----- hw/rtl/prqs_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prqs_dp
// Scheduler datapath: sorted queue memory, running task, queue walk unit.
// ----------------------------------------------------------------------------
module prqs_dp
  import prqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int LEVEL_BITS  = LEVEL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  prqs_cmd_t          cmd,
  output prqs_sts_t          sts,
  input  logic [ID_W-1:0]    task_id,
  input  logic [PRIO_W-1:0]  prio,
  output logic [ID_W-1:0]    current_task,
  output logic               current_valid,
  output logic [PRIO_W-1:0]  current_level,
  output logic               preempt_request,
  output logic [COUNT_W-1:0] ready_count,
  output logic [ERR_W-1:0]   error_code
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = LEVEL_BITS;

  logic [ID_W-1:0] mem_id  [QUEUE_DEPTH];
  logic [LW-1:0]   mem_lvl [QUEUE_DEPTH];
  logic [ID_W-1:0] rd_id;
  logic [LW-1:0]   rd_lvl;

  logic [ID_W-1:0]    req_id;
  logic [LW-1:0]      req_lvl;
  logic [CW-1:0]      len;
  logic [ID_W-1:0]    run_id;
  logic [LW-1:0]      run_lvl;
  logic               run_v;
  logic [LW-1:0]      head_lvl;
  logic [NUM_IDS-1:0] queued;
  logic [NUM_IDS-1:0] queued_next;

  logic            busy;
  logic [CW-1:0]   rd_ptr;
  logic            rvalid;
  logic [CW-1:0]   in_len;
  logic [CW-1:0]   out_cnt;
  logic            hold_v;
  logic [ID_W-1:0] hold_id;
  logic [LW-1:0]   hold_lvl;
  logic            ins_pend;
  logic [ID_W-1:0] ins_id;
  logic [LW-1:0]   ins_lvl;
  logic            rm_en;
  logic [ID_W-1:0] rm_id;
  logic            pop_en;

  logic            hold_v_next;
  logic [ID_W-1:0] hold_id_next;
  logic [LW-1:0]   hold_lvl_next;
  logic            ins_pend_next;
  logic            rd_go;
  logic            exhausted;
  logic            e_v;
  logic            emit_v;
  logic [ID_W-1:0] emit_id;
  logic [LW-1:0]   emit_lvl;
  logic            cap;
  logic            we;
  logic [CW-1:0]   widx_full;
  logic [AW-1:0]   widx;
  logic [AW-1:0]   rd_addr;
  logic            done;

  assign rd_go     = busy && (rd_ptr < in_len);
  assign exhausted = busy && (rd_ptr == in_len) && !rvalid;
  assign e_v       = rvalid && !(rm_en && (rd_id == rm_id));
  assign rd_addr   = rd_ptr[AW-1:0];

  // merge the insert word into the walked stream; hold keeps the word it displaced
  always_comb begin
    emit_v        = 1'b0;
    emit_id       = hold_id;
    emit_lvl      = hold_lvl;
    hold_v_next   = hold_v;
    hold_id_next  = hold_id;
    hold_lvl_next = hold_lvl;
    ins_pend_next = ins_pend;
    if (busy) begin
      if (hold_v) begin
        emit_v        = 1'b1;
        hold_v_next   = e_v;
        hold_id_next  = rd_id;
        hold_lvl_next = rd_lvl;
      end else if (ins_pend && ((e_v && (rd_lvl > ins_lvl)) || exhausted)) begin
        emit_v        = 1'b1;
        emit_id       = ins_id;
        emit_lvl      = ins_lvl;
        ins_pend_next = 1'b0;
        hold_v_next   = e_v;
        hold_id_next  = rd_id;
        hold_lvl_next = rd_lvl;
      end else if (e_v) begin
        emit_v   = 1'b1;
        emit_id  = rd_id;
        emit_lvl = rd_lvl;
      end
    end
  end

  assign done      = exhausted && !hold_v && !ins_pend;
  assign cap       = emit_v && pop_en && (out_cnt == '0);
  assign we        = emit_v && !cap;
  assign widx_full = out_cnt - CW'(pop_en);
  assign widx      = widx_full[AW-1:0];

  always_comb begin
    queued_next = queued;
    if (cmd.start) begin
      if (cmd.rm_en) begin
        queued_next[req_id] = 1'b0;
      end
      if (cmd.ins_en) begin
        queued_next[req_id] = 1'b1;
      end
      if (cmd.ins_cur) begin
        queued_next[run_id] = 1'b1;
      end
    end
    if (cap) begin
      queued_next[emit_id] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_id[widx]  <= emit_id;
      mem_lvl[widx] <= emit_lvl;
    end
    rd_id  <= mem_id[rd_addr];
    rd_lvl <= mem_lvl[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rvalid   <= 1'b0;
      hold_v   <= 1'b0;
      ins_pend <= 1'b0;
      len      <= '0;
      run_id   <= '0;
      run_lvl  <= '0;
      run_v    <= 1'b1;
      queued   <= '0;
    end else begin
      queued <= queued_next;
      if (cmd.set_level) begin
        run_lvl <= req_lvl;
      end
      if (cmd.start) begin
        busy     <= 1'b1;
        rd_ptr   <= '0;
        rvalid   <= 1'b0;
        out_cnt  <= '0;
        hold_v   <= 1'b0;
        in_len   <= len;
        ins_pend <= cmd.ins_en || cmd.ins_cur;
        ins_id   <= cmd.ins_cur ? run_id : req_id;
        ins_lvl  <= cmd.ins_cur ? run_lvl : req_lvl;
        rm_en    <= cmd.rm_en;
        rm_id    <= req_id;
        pop_en   <= cmd.pop;
        if (cmd.pop) begin
          run_v <= 1'b0;
        end
      end else if (busy) begin
        rvalid   <= rd_go;
        hold_v   <= hold_v_next;
        hold_id  <= hold_id_next;
        hold_lvl <= hold_lvl_next;
        ins_pend <= ins_pend_next;
        if (rd_go) begin
          rd_ptr <= rd_ptr + 1'b1;
        end
        if (emit_v) begin
          out_cnt <= out_cnt + 1'b1;
        end
        if (cap) begin
          run_id  <= emit_id;
          run_lvl <= emit_lvl;
          run_v   <= 1'b1;
        end
        if (we && (widx == '0)) begin
          head_lvl <= emit_lvl;
        end
        if (done) begin
          busy <= 1'b0;
          len  <= out_cnt - CW'(pop_en && (out_cnt != '0));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_id  <= task_id;
      req_lvl <= LW'(prio);
    end
    if (cmd.latch_out) begin
      current_task    <= run_v ? run_id : '0;
      current_valid   <= run_v;
      current_level   <= run_v ? PRIO_W'(run_lvl) : '0;
      preempt_request <= run_v && (len != '0) && (head_lvl < run_lvl);
      ready_count     <= COUNT_W'(len);
      error_code      <= cmd.err;
    end
  end

  assign sts.q_hit     = queued[req_id];
  assign sts.run_hit   = run_v && (run_id == req_id);
  assign sts.full      = (len == CW'(QUEUE_DEPTH));
  assign sts.run_valid = run_v;
  assign sts.done      = busy && done;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= CW'(QUEUE_DEPTH))
    else $error("queue length beyond depth");

  a_map_matches_len: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ($countones(queued) == int'(len)))
    else $error("id map disagrees with queue length");

  a_write_behind_read: assert property (@(posedge clk) disable iff (rst)
    we |-> (widx_full <= rd_ptr))
    else $error("queue write overtook the read pointer");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (!busy && !run_v) |-> (len == '0))
    else $error("idle with tasks still queued");

endmodule

// ----- hw/rtl/prqs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prqs_ctrl
// Scheduler controller: decodes operations, runs the queue walk, owns handshakes.
// ----------------------------------------------------------------------------
module prqs_ctrl
  import prqs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic              in_cur,
  output logic              out_valid,
  input  logic              out_ready,
  input  prqs_sts_t         sts,
  output prqs_cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_PASS,
    S_FINISH
  } state_t;

  state_t     state;
  prqs_func_t func;
  logic       cur;
  prqs_err_t  err;
  prqs_err_t  err_d;
  logic       accept;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.err       = err;
    cmd.load      = accept;
    cmd.latch_out = (state == S_FINISH) && out_free;
    err_d         = ERR_OK;
    if (state == S_DECODE) begin
      unique case (func)
        FUNC_RESUME: begin
          if (sts.q_hit || sts.run_hit) begin
            err_d = ERR_READY;
          end else if (sts.full) begin
            err_d = ERR_FULL;
          end else begin
            cmd.start  = 1'b1;
            cmd.ins_en = 1'b1;
            // idle block starts the new task at once
            cmd.pop    = !sts.run_valid;
          end
        end
        FUNC_SUSPEND: begin
          if (cur) begin
            if (sts.run_valid) begin
              cmd.start = 1'b1;
              cmd.pop   = 1'b1;
            end else begin
              err_d = ERR_NOT_QUEUED;
            end
          end else if (sts.q_hit) begin
            cmd.start = 1'b1;
            cmd.rm_en = 1'b1;
          end else begin
            err_d = ERR_NOT_QUEUED;
          end
        end
        FUNC_SET_PRIO: begin
          if (cur) begin
            if (sts.run_valid) begin
              cmd.set_level = 1'b1;
            end else begin
              err_d = ERR_NOT_QUEUED;
            end
          end else if (sts.q_hit) begin
            cmd.start  = 1'b1;
            cmd.rm_en  = 1'b1;
            cmd.ins_en = 1'b1;
          end else begin
            err_d = ERR_NOT_QUEUED;
          end
        end
        FUNC_SWITCH: begin
          if (cur && sts.run_valid) begin
            if (sts.full) begin
              err_d = ERR_FULL;
            end else begin
              cmd.start   = 1'b1;
              cmd.ins_cur = 1'b1;
              cmd.pop     = 1'b1;
            end
          end else begin
            cmd.start = 1'b1;
            cmd.pop   = 1'b1;
          end
        end
        default: begin
          err_d = ERR_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      err       <= ERR_OK;
    end else begin
      // a new word replaces the one taken in the same cycle
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            func  <= prqs_func_t'(in_func);
            cur   <= in_cur;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          err   <= err_d;
          state <= cmd.start ? S_PASS : S_FINISH;
        end
        S_PASS: begin
          if (sts.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_in_pass: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> (state == S_PASS))
    else $error("walk finished outside of a pass");

  a_start_then_pass: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == S_PASS))
    else $error("walk started without entering pass");

endmodule

// ----- hw/rtl/priority_ready_queue_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Task scheduler with a priority-sorted ready queue and a running task.
// ----------------------------------------------------------------------------
// req carries one operation per word (resume, suspend, set priority, switch);
// rsp returns one status word per operation: running task, its level, the
// preempt hint, the queue count and an error code.
// Operations are handled one at a time. Ops that do not touch the queue
// (errors, set priority of the running task) go from decode straight to finish;
// ops that rewrite the queue walk it once through the queue memory (one read
// port, one write port), one entry per cycle.
// The next word is taken as soon as the previous op has finished its work;
// the response register holds a finished word while rsp is stalled, and a
// following op waits at its end until that word has been taken.
// After reset the queue is empty and task 0 runs at level 0; the queue memory
// needs no clearing since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler
  import prqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int LEVEL_BITS  = LEVEL_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  prqs_req_if.sink   req,
  prqs_rsp_if.source rsp
);

  prqs_cmd_t cmd;
  prqs_sts_t sts;

  prqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_func   (req.func),
    .in_cur    (req.use_current),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prqs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LEVEL_BITS  (LEVEL_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .task_id         (req.task_id),
    .prio            (req.prio),
    .current_task    (rsp.current_task),
    .current_valid   (rsp.current_valid),
    .current_level   (rsp.current_level),
    .preempt_request (rsp.preempt_request),
    .ready_count     (rsp.ready_count),
    .error_code      (rsp.error_code)
  );

endmodule
